// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/gqv_pkg.sv =====
`timescale 1ns / 1ps
package gqv_pkg;

   localparam int GLYPH_COUNT = 95;
   localparam int FIRST_CODE  = 32;
   localparam int ADDR_W      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

   localparam int POS_W   = 16;
   localparam int U_W     = 16;
   localparam int GW_W    = 8;
   localparam int CODE_W  = 8;
   localparam int CFG_W   = 8;

   // Config register indexes
   localparam logic CSR_SPACE_ADVANCE = 1'b0;
   localparam logic CSR_GLYPH_HEIGHT  = 1'b1;

   localparam logic [CFG_W-1:0] SPACE_ADVANCE_RST = 8'd3;
   localparam logic [CFG_W-1:0] GLYPH_HEIGHT_RST  = 8'd32;

   localparam int          VERTS_PER_QUAD = 6;
   localparam int          VTX_CNT_W      = 3;
   localparam logic [VTX_CNT_W-1:0] LAST_VTX = VTX_CNT_W'(VERTS_PER_QUAD - 1);
   // Per-vertex corner selection, bit i for vertex i:
   // TL, BR, BL, TL, TR, BR
   localparam logic [VERTS_PER_QUAD-1:0] VTX_RIGHT  = 6'b110010;
   localparam logic [VERTS_PER_QUAD-1:0] VTX_BOTTOM = 6'b100110;

   typedef enum logic [1:0] {
      MODE_GLYPH = 2'd0,
      MODE_PEN   = 2'd1,
      MODE_DRAW  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_PEN,
      KIND_SPACE,
      KIND_DRAW
   } kind_type;

   typedef struct packed {
      logic [U_W-1:0]  left_u;
      logic [U_W-1:0]  right_u;
      logic [GW_W-1:0] width;
   } glyph_entry_type;

   localparam int ENTRY_W = $bits(glyph_entry_type);

   typedef struct packed {
      logic [POS_W-1:0] x_left;
      logic [POS_W-1:0] x_right;
      logic [POS_W-1:0] y_top;
      logic [POS_W-1:0] y_bottom;
      logic [U_W-1:0]   left_u;
      logic [U_W-1:0]   right_u;
   } quad_type;

endpackage

// ===== design/gqv_ram.sv =====
`timescale 1ns / 1ps
module gqv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/gqv_layout.sv =====
`timescale 1ns / 1ps
module gqv_layout (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  gqv_pkg::kind_type                 in_kind,
   input  logic [gqv_pkg::POS_W-1:0]         in_x,
   input  logic [gqv_pkg::POS_W-1:0]         in_y,
   output logic                              in_ready,
   input  gqv_pkg::glyph_entry_type          entry,
   input  logic [gqv_pkg::CFG_W-1:0]         space_advance,
   input  logic [gqv_pkg::CFG_W-1:0]         glyph_height,
   input  logic                              quad_ready,
   output logic                              quad_valid,
   output gqv_pkg::quad_type                 quad
);
   import gqv_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   kind_type         s1_kind_ff;
   logic [POS_W-1:0] s1_x_ff, s1_y_ff;
   logic [POS_W-1:0] pen_x_ff, pen_x_in;
   logic [POS_W-1:0] pen_y_ff, pen_y_in;
   logic             s1_done;

   assign s1_done    = s1_valid_ff && ((s1_kind_ff != KIND_DRAW) || quad_ready);
   assign in_ready   = !s1_valid_ff || s1_done;
   assign quad_valid = s1_valid_ff && (s1_kind_ff == KIND_DRAW) && quad_ready;

   always_comb begin
      quad.x_left   = pen_x_ff;
      quad.x_right  = pen_x_ff + POS_W'(entry.width);
      quad.y_top    = pen_y_ff;
      quad.y_bottom = pen_y_ff - POS_W'(glyph_height);
      quad.left_u   = entry.left_u;
      quad.right_u  = entry.right_u;
   end

   always_comb begin
      s1_valid_in = s1_done ? 1'b0 : s1_valid_ff;
      if (in_valid) begin
         s1_valid_in = 1'b1;
      end
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      if (s1_done) begin
         case (s1_kind_ff)
            KIND_PEN: begin
               pen_x_in = s1_x_ff;
               pen_y_in = s1_y_ff;
            end
            KIND_SPACE: begin
               pen_x_in = pen_x_ff + POS_W'(space_advance);
            end
            KIND_DRAW: begin
               pen_x_in = pen_x_ff + POS_W'(entry.width) + POS_W'(1);
            end
            default: begin
               pen_x_in = pen_x_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pen_x_ff    <= '0;
         pen_y_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pen_x_ff    <= pen_x_in;
         pen_y_ff    <= pen_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_kind_ff <= in_kind;
         s1_x_ff    <= in_x;
         s1_y_ff    <= in_y;
      end
   end
endmodule

// ===== design/gqv_vertex.sv =====
`timescale 1ns / 1ps
module gqv_vertex (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              quad_valid,
   input  gqv_pkg::quad_type                 quad,
   output logic                              quad_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [gqv_pkg::POS_W-1:0]  rsp_pos_x,
   output logic signed [gqv_pkg::POS_W-1:0]  rsp_pos_y,
   output logic [gqv_pkg::U_W-1:0]           rsp_tex_u,
   output logic                              rsp_tex_v_bottom,
   output logic                              rsp_last_vertex
);
   import gqv_pkg::*;

   quad_type             quad_ff;
   logic                 valid_ff, valid_in;
   logic [VTX_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 right, bottom, last;

   assign last       = (cnt_ff == LAST_VTX);
   assign quad_ready = !valid_ff || (rsp_ready && last);

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      if (quad_valid) begin
         valid_in = 1'b1;
         cnt_in   = '0;
      end else if (valid_ff && rsp_ready) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + VTX_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (quad_valid) begin
         quad_ff <= quad;
      end
   end

   assign right  = VTX_RIGHT[cnt_ff];
   assign bottom = VTX_BOTTOM[cnt_ff];

   assign rsp_valid        = valid_ff;
   assign rsp_pos_x        = right ? quad_ff.x_right : quad_ff.x_left;
   assign rsp_pos_y        = bottom ? quad_ff.y_bottom : quad_ff.y_top;
   assign rsp_tex_u        = right ? quad_ff.right_u : quad_ff.left_u;
   assign rsp_tex_v_bottom = bottom;
   assign rsp_last_vertex  = last;
endmodule

// ===== design/glyph_quad_vertex_generator_top.sv =====
`timescale 1ns / 1ps
// Bitmap-font text layout: turns character transactions into textured quad vertices.
// A glyph transaction (mode 0) writes one entry of the 95-entry glyph RAM, a pen
// transaction (mode 1) sets the pen, and a draw transaction (mode 2) either moves the
// pen by space_advance (space) or has the single vertex emitter stream six vertices,
// one per cycle while rsp_ready is high, in the order TL, BR, BL, TL, TR, BR, then
// moves the pen by glyph width plus one. Codes outside the printable range and mode
// 3 are dropped without output. Other transactions are taken one per cycle as long
// as the layout stage is not held by a glyph waiting for the emitter. Glyph RAM
// contents are undefined after reset until written; drawing an unwritten glyph gives
// undefined vertex fields. Write config only while idle; it is not enforced.
module glyph_quad_vertex_generator_top (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_mode,
   input  logic [6:0]                       req_glyph_index,
   input  logic [gqv_pkg::U_W-1:0]          req_glyph_left_u,
   input  logic [gqv_pkg::U_W-1:0]          req_glyph_right_u,
   input  logic [gqv_pkg::GW_W-1:0]         req_glyph_width,
   input  logic signed [gqv_pkg::POS_W-1:0] req_start_x,
   input  logic signed [gqv_pkg::POS_W-1:0] req_start_y,
   input  logic [gqv_pkg::CODE_W-1:0]       req_char_code,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [gqv_pkg::POS_W-1:0] rsp_pos_x,
   output logic signed [gqv_pkg::POS_W-1:0] rsp_pos_y,
   output logic [gqv_pkg::U_W-1:0]          rsp_tex_u,
   output logic                             rsp_tex_v_bottom,
   output logic                             rsp_last_vertex,
   // config
   input  logic                             csr_write_enable,
   input  logic                             csr_index,
   input  logic [gqv_pkg::CFG_W-1:0]        csr_write_data
);
   import gqv_pkg::*;

`include "assert_macros.svh"

   logic [CFG_W-1:0] space_advance_ff;
   logic [CFG_W-1:0] glyph_height_ff;

   logic            accept;
   mode_type        mode;
   logic            code_in_range, code_is_space;
   logic [CODE_W:0] code_ext;
   logic [CODE_W-1:0] slot;
   logic            ram_wr_en, ram_rd_en;
   glyph_entry_type wr_entry;
   glyph_entry_type rd_entry;
   logic            lay_valid;
   kind_type        lay_kind;
   quad_type        quad;
   logic            quad_valid, quad_ready;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         space_advance_ff <= SPACE_ADVANCE_RST;
         glyph_height_ff  <= GLYPH_HEIGHT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SPACE_ADVANCE: space_advance_ff <= csr_write_data;
            CSR_GLYPH_HEIGHT:  glyph_height_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Decode of the incoming transaction
   assign accept        = req_valid && req_ready;
   assign mode          = mode_type'(req_mode);
   assign code_ext      = {1'b0, req_char_code};
   assign code_in_range = (code_ext >= (CODE_W+1)'(FIRST_CODE)) &&
                          (code_ext < (CODE_W+1)'(FIRST_CODE + GLYPH_COUNT));
   assign code_is_space = (code_ext == (CODE_W+1)'(FIRST_CODE));
   assign slot          = req_char_code - CODE_W'(FIRST_CODE);

   assign wr_entry.left_u  = req_glyph_left_u;
   assign wr_entry.right_u = req_glyph_right_u;
   assign wr_entry.width   = req_glyph_width;

   // Table write lands at accept; a draw that follows reads at a later edge,
   // so no read/write overlap on one entry.
   assign ram_wr_en = accept && (mode == MODE_GLYPH) &&
                      ({1'b0, req_glyph_index} < 8'(GLYPH_COUNT));
   assign ram_rd_en = accept && (mode == MODE_DRAW) && code_in_range && !code_is_space;

   always_comb begin
      lay_valid = 1'b0;
      lay_kind  = KIND_PEN;
      case (mode)
         MODE_PEN: begin
            lay_valid = accept;
         end
         MODE_DRAW: begin
            lay_valid = accept && code_in_range;
            lay_kind  = code_is_space ? KIND_SPACE : KIND_DRAW;
         end
         default: begin
            lay_valid = 1'b0;
         end
      endcase
   end

   gqv_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (GLYPH_COUNT)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(req_glyph_index)),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ADDR_W'(slot)),
      .rd_data (rd_entry)
   );

   // Pen stage: sees RAM data in the cycle after accept
   gqv_layout u_layout (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (lay_valid),
      .in_kind       (lay_kind),
      .in_x          (req_start_x),
      .in_y          (req_start_y),
      .in_ready      (req_ready),
      .entry         (rd_entry),
      .space_advance (space_advance_ff),
      .glyph_height  (glyph_height_ff),
      .quad_ready    (quad_ready),
      .quad_valid    (quad_valid),
      .quad          (quad)
   );

   // Vertex emitter: six vertices per quad
   gqv_vertex u_vertex (
      .clock            (clock),
      .reset            (reset),
      .quad_valid       (quad_valid),
      .quad             (quad),
      .quad_ready       (quad_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v_bottom (rsp_tex_v_bottom),
      .rsp_last_vertex  (rsp_last_vertex)
   );

   // A quad is handed over only when the emitter can take it
   `ASSERT_IMPLY(a_quad_load_free, clock, reset, quad_valid, quad_ready)
   // A quad in flight is never cut short
   `ASSERT_NEXT(a_quad_no_drop, clock, reset, rsp_valid && rsp_ready && !rsp_last_vertex, rsp_valid)
   // The closing vertex is a bottom corner
   `ASSERT_IMPLY(a_last_bottom, clock, reset, rsp_valid && rsp_last_vertex, rsp_tex_v_bottom)

endmodule
